@@ src/sn83_pkg.sv @@
// ----------------------------------------------------------------------------
// sn83_pkg
// Shared types and constants of the 8.3 short name builder.
// ----------------------------------------------------------------------------
package sn83_pkg;

    localparam int CHAR_WIDTH     = 16;
    localparam int SHORT_WIDTH    = 7;
    localparam int BASE_SLOTS     = 8;
    localparam int EXT_SLOTS      = 3;
    localparam int BASE_CNT_WIDTH = 4;
    localparam int EXT_CNT_WIDTH  = 2;

    localparam logic [SHORT_WIDTH-1:0] CHAR_DOT = 7'h2E;

    // One bit per 7-bit code; set where the code is allowed in a short name
    localparam logic [127:0] VALID_MASK =
        128'h6FFF_FFFF_C7FF_FFFF_03FF_63FA_0000_0000;

    typedef struct packed {
        logic valid;
        logic dot;
    } sn83_class_t;

    typedef struct packed {
        logic                                ok;
        logic [BASE_SLOTS*SHORT_WIDTH-1:0]   base_chars;
        logic [BASE_CNT_WIDTH-1:0]           base_length;
        logic [EXT_SLOTS*SHORT_WIDTH-1:0]    ext_chars;
        logic [EXT_CNT_WIDTH-1:0]            ext_length;
    } sn83_result_t;

endpackage

@@ src/sn83_char_class.sv @@
// ----------------------------------------------------------------------------
// sn83_char_class
// Classifies one UTF-16 code unit: allowed in a short name, and dot.
// ----------------------------------------------------------------------------
module sn83_char_class (
    input  logic [sn83_pkg::CHAR_WIDTH-1:0] char_code,
    output sn83_pkg::sn83_class_t           char_class
);
    import sn83_pkg::*;

    logic low_range;

    // Only codes below 0x80 can be in the set
    assign low_range        = (char_code[CHAR_WIDTH-1:SHORT_WIDTH] == '0);
    assign char_class.valid = low_range && VALID_MASK[char_code[SHORT_WIDTH-1:0]];
    assign char_class.dot   = low_range && (char_code[SHORT_WIDTH-1:0] == CHAR_DOT);

endmodule

@@ src/sn83_name_state.sv @@
// ----------------------------------------------------------------------------
// sn83_name_state
// Per-name state: failure flag, base and extension stores and counts.
// Advances one beat per step and builds the result of the last beat.
// ----------------------------------------------------------------------------
module sn83_name_state #(
    parameter int BASE_LIMIT = 8,
    parameter int EXT_LIMIT  = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        last,
    input  sn83_pkg::sn83_class_t       char_class,
    input  logic [sn83_pkg::SHORT_WIDTH-1:0] char_low,
    output sn83_pkg::sn83_result_t      result
);
    import sn83_pkg::*;

    logic                      failed_reg, failed_next;
    logic                      first_reg, first_next;
    logic                      in_ext_reg, in_ext_next;
    logic [BASE_CNT_WIDTH-1:0] base_count_reg, base_count_next;
    logic [EXT_CNT_WIDTH-1:0]  ext_count_reg, ext_count_next;
    logic [SHORT_WIDTH-1:0]    base_store_reg [BASE_LIMIT];
    logic [SHORT_WIDTH-1:0]    base_store_next [BASE_LIMIT];
    logic [SHORT_WIDTH-1:0]    ext_store_reg [EXT_LIMIT];
    logic [SHORT_WIDTH-1:0]    ext_store_next [EXT_LIMIT];

    // Updated state after the current beat, before the end-of-name clear
    always_comb
    begin
        failed_next     = failed_reg;
        in_ext_next     = in_ext_reg;
        base_count_next = base_count_reg;
        ext_count_next  = ext_count_reg;
        base_store_next = base_store_reg;
        ext_store_next  = ext_store_reg;
        if (!failed_reg)
        begin
            if (!char_class.valid || (first_reg && char_class.dot))
            begin
                failed_next = 1'b1;
            end
            else if (char_class.dot)
            begin
                // every dot restarts the extension
                in_ext_next    = 1'b1;
                ext_count_next = '0;
                for (int i = 0; i < EXT_LIMIT; i++)
                begin
                    ext_store_next[i] = '0;
                end
            end
            else if (in_ext_reg)
            begin
                if (ext_count_reg < EXT_CNT_WIDTH'(EXT_LIMIT))
                begin
                    for (int i = 0; i < EXT_LIMIT; i++)
                    begin
                        if (ext_count_reg == EXT_CNT_WIDTH'(i))
                        begin
                            ext_store_next[i] = char_low;
                        end
                    end
                    ext_count_next = ext_count_reg + 1'b1;
                end
            end
            else if (base_count_reg < BASE_CNT_WIDTH'(BASE_LIMIT))
            begin
                for (int i = 0; i < BASE_LIMIT; i++)
                begin
                    if (base_count_reg == BASE_CNT_WIDTH'(i))
                    begin
                        base_store_next[i] = char_low;
                    end
                end
                base_count_next = base_count_reg + 1'b1;
            end
        end
        first_next = 1'b0;
    end

    // Unused slots stay zero, so the stores pack straight into the result
    logic [BASE_SLOTS*SHORT_WIDTH-1:0] base_packed;
    logic [EXT_SLOTS*SHORT_WIDTH-1:0]  ext_packed;

    for (genvar g = 0; g < BASE_SLOTS; g++)
    begin : g_base_pack
        if (g < BASE_LIMIT)
        begin : g_used
            assign base_packed[g*SHORT_WIDTH +: SHORT_WIDTH] = base_store_next[g];
        end
        else
        begin : g_unused
            assign base_packed[g*SHORT_WIDTH +: SHORT_WIDTH] = '0;
        end
    end

    for (genvar g = 0; g < EXT_SLOTS; g++)
    begin : g_ext_pack
        if (g < EXT_LIMIT)
        begin : g_used
            assign ext_packed[g*SHORT_WIDTH +: SHORT_WIDTH] = ext_store_next[g];
        end
        else
        begin : g_unused
            assign ext_packed[g*SHORT_WIDTH +: SHORT_WIDTH] = '0;
        end
    end

    always_comb
    begin
        result.ok          = !failed_next;
        result.base_chars  = failed_next ? '0 : base_packed;
        result.base_length = failed_next ? '0 : base_count_next;
        result.ext_chars   = failed_next ? '0 : ext_packed;
        result.ext_length  = failed_next ? '0 : ext_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg     <= 1'b0;
            first_reg      <= 1'b1;
            in_ext_reg     <= 1'b0;
            base_count_reg <= '0;
            ext_count_reg  <= '0;
            for (int i = 0; i < BASE_LIMIT; i++)
            begin
                base_store_reg[i] <= '0;
            end
            for (int i = 0; i < EXT_LIMIT; i++)
            begin
                ext_store_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (last)
            begin
                // name complete: back to the empty state
                failed_reg     <= 1'b0;
                first_reg      <= 1'b1;
                in_ext_reg     <= 1'b0;
                base_count_reg <= '0;
                ext_count_reg  <= '0;
                for (int i = 0; i < BASE_LIMIT; i++)
                begin
                    base_store_reg[i] <= '0;
                end
                for (int i = 0; i < EXT_LIMIT; i++)
                begin
                    ext_store_reg[i] <= '0;
                end
            end
            else
            begin
                failed_reg     <= failed_next;
                first_reg      <= first_next;
                in_ext_reg     <= in_ext_next;
                base_count_reg <= base_count_next;
                ext_count_reg  <= ext_count_next;
                base_store_reg <= base_store_next;
                ext_store_reg  <= ext_store_next;
            end
        end
    end

endmodule

@@ src/short_name_8_3_builder.sv @@
// ----------------------------------------------------------------------------
// short_name_8_3_builder
// Builds a DOS-style 8.3 short name from a long name, one character a beat.
//
//   Channel | Signals                                   | Beat
//   --------+-------------------------------------------+-------------------
//   in      | in_valid/in_ready, char_code,last_of_name | one name character
//   out     | out_valid/out_ready, name_ok, base_chars, | one short name per
//           | base_length, ext_chars, ext_length        | flagged last beat
//
// One character per cycle while no last character waits on a stalled result:
// an input register feeds the classifier and state update, and the result
// register takes the outcome of the last character, raising out_valid.
// Reset returns to the empty-name state; no clearing pass is needed.
// A stalled result holds only the last character of the next name; other
// characters keep flowing.
// ----------------------------------------------------------------------------
module short_name_8_3_builder #(
    parameter int BASE_LIMIT = 8,
    parameter int EXT_LIMIT  = 3
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [sn83_pkg::CHAR_WIDTH-1:0]                       char_code,
    input  logic                                                  last_of_name,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic                                                  name_ok,
    output logic [sn83_pkg::BASE_SLOTS*sn83_pkg::SHORT_WIDTH-1:0] base_chars,
    output logic [sn83_pkg::BASE_CNT_WIDTH-1:0]                   base_length,
    output logic [sn83_pkg::EXT_SLOTS*sn83_pkg::SHORT_WIDTH-1:0]  ext_chars,
    output logic [sn83_pkg::EXT_CNT_WIDTH-1:0]                    ext_length
);
    import sn83_pkg::*;

    logic                  held_valid_reg;
    logic [CHAR_WIDTH-1:0] char_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    sn83_result_t          result_reg;
    sn83_result_t          result;
    sn83_class_t           char_class;
    logic                  step;

    // A held last character waits for room in the result register
    assign step     = held_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !held_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            held_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
            last_reg <= last_of_name;
        end
    end

    sn83_char_class u_class (
        .char_code  (char_reg),
        .char_class (char_class)
    );

    sn83_name_state #(
        .BASE_LIMIT (BASE_LIMIT),
        .EXT_LIMIT  (EXT_LIMIT)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .last       (last_reg),
        .char_class (char_class),
        .char_low   (char_reg[SHORT_WIDTH-1:0]),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign name_ok     = result_reg.ok;
    assign base_chars  = result_reg.base_chars;
    assign base_length = result_reg.base_length;
    assign ext_chars   = result_reg.ext_chars;
    assign ext_length  = result_reg.ext_length;

endmodule

@@ src/sn83_checker.sv @@
// ----------------------------------------------------------------------------
// sn83_checker
// Port-level checks of the short name builder, bound to the top level.
// ----------------------------------------------------------------------------
module sn83_checker #(
    parameter int BASE_LIMIT = 8,
    parameter int EXT_LIMIT  = 3
) (
    input logic                                                  clk,
    input logic                                                  rst_n,
    input logic                                                  in_valid,
    input logic                                                  in_ready,
    input logic                                                  out_valid,
    input logic                                                  out_ready,
    input logic                                                  name_ok,
    input logic [sn83_pkg::BASE_SLOTS*sn83_pkg::SHORT_WIDTH-1:0] base_chars,
    input logic [sn83_pkg::BASE_CNT_WIDTH-1:0]                   base_length,
    input logic [sn83_pkg::EXT_SLOTS*sn83_pkg::SHORT_WIDTH-1:0]  ext_chars,
    input logic [sn83_pkg::EXT_CNT_WIDTH-1:0]                    ext_length
);
    import sn83_pkg::*;

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(name_ok)
            && $stable(base_chars) && $stable(base_length)
            && $stable(ext_chars) && $stable(ext_length))
    else $error("stalled result beat changed");

    // A failed name carries no characters
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !name_ok |-> base_length == '0 && ext_length == '0
            && base_chars == '0 && ext_chars == '0)
    else $error("failed name carries characters");

    // Lengths stay within the configured limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> base_length <= BASE_CNT_WIDTH'(BASE_LIMIT)
            && ext_length <= EXT_CNT_WIDTH'(EXT_LIMIT))
    else $error("length beyond limit");

    // Empty fields leave their character slots zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (base_length != '0 || base_chars == '0)
            && (ext_length != '0 || ext_chars == '0))
    else $error("characters present with zero length");

    // Input side never refuses a beat while nothing is held
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!in_valid) && !out_valid |-> in_ready)
    else $error("input stalled while empty");

endmodule

bind short_name_8_3_builder sn83_checker #(
    .BASE_LIMIT (BASE_LIMIT),
    .EXT_LIMIT  (EXT_LIMIT)
) u_sn83_checker (.*);

@@ test/short_name_8_3_builder_tb.sv @@
// ----------------------------------------------------------------------------
// short_name_8_3_builder_tb
// Drives long names into the 8.3 short name builder one character a beat and
// checks every short name that comes out against an in-bench predictor, with
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module short_name_8_3_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sn83_pkg::*;

    localparam int    BASE_LIMIT   = 8;
    localparam int    EXT_LIMIT    = 3;
    localparam int    RANDOM_ITEMS = 900;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    HOLD_AFTER   = 40;
    localparam int    DRAIN_CYCLES = 8;
    localparam string NAME_CHARS   =
        ".!#$%&'()-0123456789@ABCDEFGHIJKLMNOPQRSTUVWXYZ^_\140abcdefghijklmnopqrstuvwxyz{}~";
    localparam logic [CHAR_WIDTH-1:0] DOT_CODE = {{(CHAR_WIDTH-SHORT_WIDTH){1'b0}}, CHAR_DOT};

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [CHAR_WIDTH-1:0]               char_code;
    logic                                last_of_name;
    logic                                out_valid;
    logic                                out_ready;
    logic                                name_ok;
    logic [BASE_SLOTS*SHORT_WIDTH-1:0]   base_chars;
    logic [BASE_CNT_WIDTH-1:0]           base_length;
    logic [EXT_SLOTS*SHORT_WIDTH-1:0]    ext_chars;
    logic [EXT_CNT_WIDTH-1:0]            ext_length;

    // Predicts short names from accepted characters and checks the results
    class short_name_scoreboard;
        bit                      failed;
        bit                      first;
        bit                      in_ext;
        logic [SHORT_WIDTH-1:0]  base_q [BASE_SLOTS];
        int unsigned             base_n;
        logic [SHORT_WIDTH-1:0]  ext_q [EXT_SLOTS];
        int unsigned             ext_n;
        sn83_result_t            expected_names [$];
        int                      errors;
        int                      names_seen;

        function new();
            errors     = 0;
            names_seen = 0;
            clear();
        endfunction

        function void clear();
            failed = 1'b0;
            first  = 1'b1;
            in_ext = 1'b0;
            base_n = 0;
            ext_n  = 0;
            foreach (base_q[k]) base_q[k] = '0;
            foreach (ext_q[k]) ext_q[k] = '0;
        endfunction

        function bit legal_char(logic [CHAR_WIDTH-1:0] c);
            string legal;
            legal = NAME_CHARS;
            if (c <= 16'h0020 || c >= 16'h0080)
                return 1'b0;
            for (int k = 0; k < legal.len(); k++)
                if (c[7:0] == legal[k])
                    return 1'b1;
            return 1'b0;
        endfunction

        function int pending();
            return expected_names.size();
        endfunction

        function void note_char(logic [CHAR_WIDTH-1:0] c, logic last);
            sn83_result_t want;
            if (!failed) begin
                if (first && c == DOT_CODE)
                    failed = 1'b1;
                else if (!legal_char(c))
                    failed = 1'b1;
                else if (c == DOT_CODE) begin
                    // every dot restarts the extension
                    in_ext = 1'b1;
                    ext_n  = 0;
                    foreach (ext_q[k]) ext_q[k] = '0;
                end
                else if (in_ext) begin
                    if (ext_n < EXT_LIMIT) begin
                        ext_q[ext_n] = c[SHORT_WIDTH-1:0];
                        ext_n++;
                    end
                end
                else if (base_n < BASE_LIMIT) begin
                    base_q[base_n] = c[SHORT_WIDTH-1:0];
                    base_n++;
                end
            end
            first = 1'b0;
            if (last) begin
                want = '0;
                want.ok = !failed;
                if (!failed) begin
                    for (int k = 0; k < base_n; k++)
                        want.base_chars[k*SHORT_WIDTH +: SHORT_WIDTH] = base_q[k];
                    for (int k = 0; k < ext_n; k++)
                        want.ext_chars[k*SHORT_WIDTH +: SHORT_WIDTH] = ext_q[k];
                    want.base_length = base_n[BASE_CNT_WIDTH-1:0];
                    want.ext_length  = ext_n[EXT_CNT_WIDTH-1:0];
                end
                expected_names.push_back(want);
                clear();
            end
        endfunction

        task report(string what);
            $display("MISMATCH name %0d: %s", names_seen, what);
            errors++;
        endtask

        task check_name(sn83_result_t got);
            sn83_result_t want;
            if (expected_names.size() == 0) begin
                report($sformatf("short name with no name pending (ok=%0b)", got.ok));
                return;
            end
            want = expected_names.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("name_ok %0b, want %0b", got.ok, want.ok));
            if (got.base_chars !== want.base_chars)
                report($sformatf("base_chars %h, want %h", got.base_chars, want.base_chars));
            if (got.base_length !== want.base_length)
                report($sformatf("base_length %0d, want %0d",
                                 got.base_length, want.base_length));
            if (got.ext_chars !== want.ext_chars)
                report($sformatf("ext_chars %h, want %h", got.ext_chars, want.ext_chars));
            if (got.ext_length !== want.ext_length)
                report($sformatf("ext_length %0d, want %0d",
                                 got.ext_length, want.ext_length));
            names_seen++;
        endtask
    endclass

    short_name_scoreboard  sb = new();
    logic [CHAR_WIDTH-1:0] name_buf [$];
    int                    items_sent;
    int                    tx_run;
    bit                    tx_burst;

    short_name_8_3_builder #(
        .BASE_LIMIT (BASE_LIMIT),
        .EXT_LIMIT  (EXT_LIMIT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .last_of_name (last_of_name),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .name_ok      (name_ok),
        .base_chars   (base_chars),
        .base_length  (base_length),
        .ext_chars    (ext_chars),
        .ext_length   (ext_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_400_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_char(char_code, last_of_name);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_name({name_ok, base_chars, base_length, ext_chars, ext_length});
    end

    function logic [CHAR_WIDTH-1:0] name_char();
        // any legal character except the dot
        return {8'h00, NAME_CHARS[$urandom_range(1, NAME_CHARS.len() - 1)]};
    endfunction

    function logic [CHAR_WIDTH-1:0] noise_char();
        if ($urandom_range(0, 1) == 0)
            return CHAR_WIDTH'($urandom_range(0, 16'hFFFF));
        return CHAR_WIDTH'($urandom_range(0, 127));
    endfunction

    function void load_text(string s);
        name_buf.delete();
        for (int k = 0; k < s.len(); k++)
            name_buf.push_back({8'h00, s[k]});
    endfunction

    function void make_random_name();
        int shape;
        int sections;
        name_buf.delete();
        shape = $urandom_range(0, 99);
        if (shape < 75) begin
            repeat ($urandom_range(1, 11)) name_buf.push_back(name_char());
            sections = $urandom_range(0, 2);
            repeat (sections) begin
                name_buf.push_back(DOT_CODE);
                repeat ($urandom_range(0, 5)) name_buf.push_back(name_char());
            end
            if ($urandom_range(0, 9) == 0)
                name_buf[$urandom_range(0, name_buf.size() - 1)] = noise_char();
        end
        else if (shape < 85) begin
            name_buf.push_back(DOT_CODE);
            repeat ($urandom_range(0, 6)) name_buf.push_back(name_char());
        end
        else begin
            repeat ($urandom_range(1, 10))
                name_buf.push_back($urandom_range(0, 1) ? noise_char() : name_char());
        end
    endfunction

    task send_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
        int gap;
        if (tx_run == 0) begin
            tx_run   = $urandom_range(4, 30);
            tx_burst = ($urandom_range(0, 3) == 0);
        end
        tx_run--;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_code    <= c;
        last_of_name <= last;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task send_name();
        foreach (name_buf[k])
            send_char(name_buf[k], k == name_buf.size() - 1);
    endtask

    // Result side: random gaps, plus one long hold while names keep arriving
    initial
    begin
        int rx_gap;
        int rx_run;
        bit rx_burst;
        bit held;
        rx_run = 0;
        held   = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!held && sb.names_seen >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (rx_run == 0) begin
                rx_run   = $urandom_range(4, 20);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            rx_run--;
            rx_gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (rx_gap > 0) begin
                out_ready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_code    = '0;
        last_of_name = 1'b0;
        out_ready    = 1'b0;
        items_sent   = 0;
        tx_run       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_text(".");                     send_name();  // lone dot
        load_text("~");                     send_name();
        load_text(".A");                    send_name();  // leading dot
        load_text("AB.");                   send_name();  // trailing dot
        load_text("AbcdefghI.x.KLmn");      send_name();  // overflow, dot restarts
        name_buf = '{16'hFFFF};             send_name();
        name_buf = '{16'h0020};             send_name();
        name_buf = '{16'h007F};             send_name();
        name_buf = '{16'h0080};             send_name();
        name_buf = '{16'h0078, 16'h0000, DOT_CODE}; send_name();  // rest ignored

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            make_random_name();
            send_name();
        end
        in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
